// File: rtl/stereo_stutter_looper_core_macros.svh
// Assertion macros used by the looper core RTL.
`ifndef STEREO_STUTTER_LOOPER_CORE_MACROS_SVH
`define STEREO_STUTTER_LOOPER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define SSLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sslc assertion failed");

// Next-cycle implication, disabled during reset
`define SSLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sslc assertion failed");

`else

`define SSLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SSLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sslc_pkg.sv
package sslc_pkg;

    // Default sizes
    localparam int SSLC_BUFFER_DEPTH = 32768;
    localparam int SSLC_SAMPLE_BITS  = 16;

    // Register file
    localparam int SSLC_REG_W  = 16;
    localparam int SSLC_ADDR_W = 4;
    localparam int SSLC_DATA_W = 32;

    // Q2.15 gains: two integer bits above the fraction, unity = 1 << 15
    localparam int SSLC_Q_FRAC = 15;
    localparam int SSLC_GAIN_W = SSLC_Q_FRAC + 2;
    localparam logic [SSLC_GAIN_W-1:0] SSLC_UNITY = SSLC_GAIN_W'(1) << SSLC_Q_FRAC;

    // Register reset values
    localparam logic [SSLC_REG_W-1:0] SSLC_CHUNK_LEN_RST = 16'd4800;
    localparam logic [SSLC_REG_W-1:0] SSLC_LOOP_GAIN_RST = 16'd32768;
    localparam logic [SSLC_REG_W-1:0] SSLC_DRY_GAIN_RST  = 16'd0;
    localparam logic [SSLC_REG_W-1:0] SSLC_WET_MIX_RST   = 16'd32768;

    typedef enum logic [1:0] {
        REG_CHUNK_LEN,
        REG_LOOP_GAIN,
        REG_DRY_GAIN,
        REG_WET_MIX
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_REC,
        MODE_LOOP
    } t_mode;

    // Clamped gains handed to the mixing lanes
    typedef struct packed {
        logic [SSLC_GAIN_W-1:0] loop_gain;
        logic [SSLC_GAIN_W-1:0] dry_gain;
        logic [SSLC_GAIN_W-1:0] wet_mix;
    } t_gains;

    // Anything above unity acts as unity
    function automatic logic [SSLC_GAIN_W-1:0] clamp_gain(input logic [SSLC_REG_W-1:0] g);
        logic [SSLC_GAIN_W-1:0] ext;
        ext = SSLC_GAIN_W'(g);
        return (ext > SSLC_UNITY) ? SSLC_UNITY : ext;
    endfunction

endpackage

// File: rtl/sslc_if.sv
// Input channel: gate plus one stereo pair per word
interface sslc_in_if #(
    parameter int SAMPLE_BITS = sslc_pkg::SSLC_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          stutter_on;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;

    modport source (output valid, output stutter_on, output in_left, output in_right,
                    input ready);
    modport sink   (input valid, input stutter_on, input in_left, input in_right,
                    output ready);
endinterface

// Output channel: one stereo pair per word
interface sslc_out_if #(
    parameter int SAMPLE_BITS = sslc_pkg::SSLC_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// File: rtl/sslc_mix_lane.sv
// One channel of the loop mix, two register stages:
//   stage A: stored*loop_gain + in*dry_gain, and in*(unity - wet_mix)
//   stage B: wet*wet_mix
// then round half up at 2^30 and saturate (combinational off stage B).
module sslc_mix_lane #(
    parameter int SAMPLE_BITS = sslc_pkg::SSLC_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_s,
    input  sslc_pkg::t_gains              i_gains,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import sslc_pkg::*;

    localparam int GS_W   = SSLC_GAIN_W + 1;      // gain with a sign bit
    localparam int PROD_W = SAMPLE_BITS + GS_W;
    localparam int WET_W  = PROD_W + 1;
    localparam int WWM_W  = WET_W + GS_W;
    localparam int ACC_W  = WWM_W + 1;
    localparam int FRAC   = 2 * SSLC_Q_FRAC;
    localparam int Q_W    = ACC_W - FRAC;

    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   Q_MIN = -Q_MAX - 1;

    logic signed [GS_W-1:0]   w_lg;
    logic signed [GS_W-1:0]   w_dg;
    logic signed [GS_W-1:0]   w_wm;
    logic signed [GS_W-1:0]   w_dm;
    logic signed [PROD_W-1:0] w_ps;
    logic signed [PROD_W-1:0] w_px;
    logic signed [PROD_W-1:0] w_dry;
    logic signed [WET_W-1:0]  w_wet;
    logic signed [WET_W-1:0]  r_wet;
    logic signed [PROD_W-1:0] r_dry_a;
    logic signed [WWM_W-1:0]  r_wwm;
    logic signed [PROD_W-1:0] r_dry_b;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [Q_W-1:0]    w_q;

    // Gains as positive signed operands
    assign w_lg = $signed({1'b0, i_gains.loop_gain});
    assign w_dg = $signed({1'b0, i_gains.dry_gain});
    assign w_wm = $signed({1'b0, i_gains.wet_mix});
    assign w_dm = $signed({1'b0, SSLC_UNITY - i_gains.wet_mix});

    // Stage A products
    assign w_ps  = i_s * w_lg;
    assign w_px  = i_x * w_dg;
    assign w_dry = i_x * w_dm;
    assign w_wet = WET_W'(w_ps) + WET_W'(w_px);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wet   <= w_wet;
            r_dry_a <= w_dry;
        end
    end

    // Stage B: wet path scaled by the mix
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wwm   <= r_wet * w_wm;
            r_dry_b <= r_dry_a;
        end
    end

    // Sum, round, saturate
    assign w_acc = (ACC_W'(r_dry_b) <<< SSLC_Q_FRAC) + ACC_W'(r_wwm) + RND;
    assign w_q   = w_acc[ACC_W-1:FRAC];

    always_comb begin
        if (w_q > Q_MAX) begin
            o_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (w_q < Q_MIN) begin
            o_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_y = w_q[SAMPLE_BITS-1:0];
        end
    end

endmodule

// File: rtl/stereo_stutter_looper_core.sv
// Channel   Dir   Handshake          Word
// i_in      in    valid/ready        stutter_on, in_left, in_right
// o_out     out   valid/ready        out_left, out_right
// apb       in    psel/penable/pwrite  4 x 16-bit registers at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle while output words are taken; an accepted word passes through the
// store read register, the two mix stages and the output register, in that order.
// Each word makes at most one access to each sample store: a write while recording, a read
// while looping, none with the gate low, so the single port of each store sets the rate.
// Synchronous active-low reset clears mode, indices, valids and registers; the
// stores are not cleared and need no clearing pass.
// A held output word that is not taken stalls the whole pipeline and i_in.ready.
`include "stereo_stutter_looper_core_macros.svh"

module stereo_stutter_looper_core #(
    parameter int BUFFER_DEPTH = sslc_pkg::SSLC_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = sslc_pkg::SSLC_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sslc_in_if.sink                            i_in,
    sslc_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sslc_pkg::SSLC_ADDR_W-1:0]   paddr,
    input  logic [sslc_pkg::SSLC_DATA_W-1:0]   pwdata,
    output logic [sslc_pkg::SSLC_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import sslc_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);

    // Configuration
    logic [SSLC_REG_W-1:0] r_chunk_len;
    logic [SSLC_REG_W-1:0] r_loop_gain;
    logic [SSLC_REG_W-1:0] r_dry_gain;
    logic [SSLC_REG_W-1:0] r_wet_mix;
    logic                  w_cfg_wr;
    t_reg_idx              w_reg_sel;
    logic [LEN_W-1:0]      w_len;
    t_gains                w_gains;

    // Control
    logic                  w_adv;
    logic                  w_accept;
    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [LEN_W-1:0]      r_rec_idx;
    logic [LEN_W-1:0]      n_rec_idx;
    logic [ADDR_W-1:0]     r_play_idx;
    logic [ADDR_W-1:0]     n_play_idx;
    logic [LEN_W-1:0]      w_rec_inc;
    logic [LEN_W-1:0]      w_play_inc;
    logic                  w_rec_done;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic                  w_mix;

    // Stores and pipeline
    logic signed [SAMPLE_BITS-1:0] r_mem_l [BUFFER_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_mem_r [BUFFER_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_l;
    logic signed [SAMPLE_BITS-1:0] r_rd_r;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic                          r_mix1;
    logic                          r_mix2;
    logic                          r_mix3;
    logic signed [SAMPLE_BITS-1:0] r_x1_l;
    logic signed [SAMPLE_BITS-1:0] r_x1_r;
    logic signed [SAMPLE_BITS-1:0] r_x2_l;
    logic signed [SAMPLE_BITS-1:0] r_x2_r;
    logic signed [SAMPLE_BITS-1:0] r_x3_l;
    logic signed [SAMPLE_BITS-1:0] r_x3_r;
    logic signed [SAMPLE_BITS-1:0] w_y_l;
    logic signed [SAMPLE_BITS-1:0] w_y_r;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = t_reg_idx'(paddr[SSLC_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len <= SSLC_CHUNK_LEN_RST;
            r_loop_gain <= SSLC_LOOP_GAIN_RST;
            r_dry_gain  <= SSLC_DRY_GAIN_RST;
            r_wet_mix   <= SSLC_WET_MIX_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_sel)
                REG_CHUNK_LEN: r_chunk_len <= pwdata[SSLC_REG_W-1:0];
                REG_LOOP_GAIN: r_loop_gain <= pwdata[SSLC_REG_W-1:0];
                REG_DRY_GAIN:  r_dry_gain  <= pwdata[SSLC_REG_W-1:0];
                REG_WET_MIX:   r_wet_mix   <= pwdata[SSLC_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_CHUNK_LEN: prdata = SSLC_DATA_W'(r_chunk_len);
            REG_LOOP_GAIN: prdata = SSLC_DATA_W'(r_loop_gain);
            REG_DRY_GAIN:  prdata = SSLC_DATA_W'(r_dry_gain);
            REG_WET_MIX:   prdata = SSLC_DATA_W'(r_wet_mix);
            default:       prdata = '0;
        endcase
    end

    // Effective chunk length, 1 .. BUFFER_DEPTH
    always_comb begin
        if (r_chunk_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_chunk_len) > 32'(BUFFER_DEPTH)) begin
            w_len = LEN_W'(BUFFER_DEPTH);
        end else begin
            w_len = LEN_W'(r_chunk_len);
        end
    end

    assign w_gains.loop_gain = clamp_gain(r_loop_gain);
    assign w_gains.dry_gain  = clamp_gain(r_dry_gain);
    assign w_gains.wet_mix   = clamp_gain(r_wet_mix);

    // ---------------- handshake ----------------
    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_adv;
    assign w_accept    = i_in.valid && w_adv;

    // ---------------- record / loop control ----------------
    // record index is zero in idle, so a fresh recording starts at entry 0
    assign w_rec_inc  = r_rec_idx + LEN_W'(1);
    assign w_rec_done = (w_rec_inc >= w_len);
    assign w_play_inc = LEN_W'(r_play_idx) + LEN_W'(1);

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (w_accept) begin
            if (!i_in.stutter_on) begin
                n_mode = MODE_IDLE;
            end else begin
                case (r_mode)
                    MODE_IDLE, MODE_REC: n_mode = w_rec_done ? MODE_LOOP : MODE_REC;
                    MODE_LOOP:           n_mode = MODE_LOOP;
                    default:             n_mode = MODE_IDLE;
                endcase
            end
        end
    end

    // indices and store strobes
    always_comb begin
        n_rec_idx  = r_rec_idx;
        n_play_idx = r_play_idx;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_mix      = 1'b0;
        if (w_accept) begin
            if (!i_in.stutter_on) begin
                n_rec_idx  = '0;
                n_play_idx = '0;
            end else begin
                case (r_mode)
                    MODE_IDLE, MODE_REC: begin
                        w_wr_en   = 1'b1;
                        n_rec_idx = w_rec_inc;
                        if (w_rec_done) begin
                            n_play_idx = '0;
                        end
                    end
                    MODE_LOOP: begin
                        w_rd_en    = 1'b1;
                        w_mix      = 1'b1;
                        n_play_idx = (w_play_inc >= w_len) ? '0 : w_play_inc[ADDR_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_rec_idx  <= '0;
            r_play_idx <= '0;
        end else begin
            r_mode     <= n_mode;
            r_rec_idx  <= n_rec_idx;
            r_play_idx <= n_play_idx;
        end
    end

    // ---------------- sample stores ----------------
    // A word writes or reads, never both; a later word's read comes after any earlier write
    // has been stored, so it always sees the new data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_l[r_rec_idx[ADDR_W-1:0]] <= i_in.in_left;
        end
        if (w_rd_en) begin
            r_rd_l <= r_mem_l[r_play_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_r[r_rec_idx[ADDR_W-1:0]] <= i_in.in_right;
        end
        if (w_rd_en) begin
            r_rd_r <= r_mem_r[r_play_idx];
        end
    end

    // ---------------- pipeline ----------------
    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= w_accept;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // stage 1 payload lines up with the store read data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mix1 <= w_mix;
            r_x1_l <= i_in.in_left;
            r_x1_r <= i_in.in_right;
        end
    end

    // bypass samples travel beside the mix lanes
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mix2 <= r_mix1;
            r_mix3 <= r_mix2;
            r_x2_l <= r_x1_l;
            r_x2_r <= r_x1_r;
            r_x3_l <= r_x2_l;
            r_x3_r <= r_x2_r;
        end
    end

    sslc_mix_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (r_x1_l),
        .i_s     (r_rd_l),
        .i_gains (w_gains),
        .o_y     (w_y_l)
    );

    sslc_mix_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (r_x1_r),
        .i_s     (r_rd_r),
        .i_gains (w_gains),
        .o_y     (w_y_r)
    );

    // output register: looped mix or dry pass-through
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_l <= r_mix3 ? w_y_l : r_x3_l;
            r_out_r <= r_mix3 ? w_y_r : r_x3_r;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;

    // ---------------- checks ----------------
    `SSLC_ASSERT_IMPL(a_idle_idx_zero, i_clk, i_rst_n, r_mode == MODE_IDLE,
                      r_rec_idx == '0 && r_play_idx == '0)
    `SSLC_ASSERT_IMPL(a_rec_idx_range, i_clk, i_rst_n, r_mode == MODE_REC,
                      32'(r_rec_idx) < 32'(BUFFER_DEPTH))
    `SSLC_ASSERT_IMPL(a_one_store_access, i_clk, i_rst_n, w_wr_en, !w_rd_en)
    `SSLC_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !o_out.ready,
                      !i_in.ready)
    `SSLC_ASSERT_NEXT(a_gate_low_clears, i_clk, i_rst_n, w_accept && !i_in.stutter_on,
                      r_mode == MODE_IDLE)

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import sslc_pkg::*;

    localparam int DEPTH      = SSLC_BUFFER_DEPTH;
    localparam int IDLE_LIMIT = 1000;

    // One input word as queued for the driver, with the idle cycles to insert before it
    typedef struct packed {
        logic               stutter;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [4:0]         gap;
    } t_stim_word;

    // One output pair
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_pair;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [SSLC_ADDR_W-1:0] paddr;
    logic [SSLC_DATA_W-1:0] pwdata;
    logic [SSLC_DATA_W-1:0] prdata;
    logic pready;

    sslc_in_if  #(.SAMPLE_BITS(SSLC_SAMPLE_BITS)) in_ch ();
    sslc_out_if #(.SAMPLE_BITS(SSLC_SAMPLE_BITS)) out_ch ();

    stereo_stutter_looper_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the registers
    logic [15:0] cfg_chunk;
    logic [15:0] cfg_loop_gain;
    logic [15:0] cfg_dry_gain;
    logic [15:0] cfg_wet_mix;

    // Shadow copy of the looper state
    logic signed [15:0] left_take  [DEPTH];
    logic signed [15:0] right_take [DEPTH];
    int unsigned rec_pos;
    int unsigned play_pos;
    bit          capturing;
    bit          chunk_held;
    int unsigned take_extent;   // entries 0 .. take_extent-1 have been written

    t_stim_word pending_q [$];
    t_pair      expected_q [$];
    t_stim_word cur_word;
    t_pair      want;

    int unsigned source_gap_max;
    int unsigned sink_stall_max;
    int unsigned src_wait;
    int unsigned sink_hold;
    int unsigned quiet_cycles;

    int n_words_in;
    int n_words_out;
    int n_looped;
    int n_chunks;
    int n_reg_writes;
    int n_phases;
    int n_errors;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // Effective loop length: zero acts as one, anything past the store acts as its depth
    function automatic int unsigned chunk_span();
        if (cfg_chunk == 16'd0) return 1;
        if (int'(cfg_chunk) > DEPTH) return DEPTH;
        return int'(cfg_chunk);
    endfunction

    function automatic longint gain_q15(input logic [15:0] g);
        return (g > 16'd32768) ? 64'sd32768 : longint'({48'd0, g});
    endfunction

    // Loop blend of one channel, rounded half up at 2^30 and saturated
    function automatic logic signed [15:0] blend(input logic signed [15:0] x,
                                                 input logic signed [15:0] s);
        longint lg;
        longint dg;
        longint wm;
        longint wet;
        longint acc;
        lg  = gain_q15(cfg_loop_gain);
        dg  = gain_q15(cfg_dry_gain);
        wm  = gain_q15(cfg_wet_mix);
        wet = longint'(s) * lg + longint'(x) * dg;
        acc = longint'(x) * (64'sd32768 - wm) * 64'sd32768 + wet * wm;
        acc = (acc + (64'sd1 <<< 29)) >>> 30;
        if (acc > 64'sd32767) return 16'sh7FFF;
        if (acc < -64'sd32768) return 16'sh8000;
        return acc[15:0];
    endfunction

    // Advance the shadow looper by one accepted word and queue what should come out
    task automatic predict_word(input t_stim_word w);
        t_pair       e;
        int unsigned len;
        int unsigned r;
        len     = chunk_span();
        e.left  = w.left;
        e.right = w.right;
        if (w.stutter) begin
            if (!capturing && !chunk_held) begin
                capturing = 1'b1;
                rec_pos   = 0;
            end
            if (capturing) begin
                r = rec_pos % DEPTH;
                left_take[r]  = w.left;
                right_take[r] = w.right;
                if (r + 1 > take_extent) take_extent = r + 1;
                rec_pos = (rec_pos + 1) & 32'h1FFFF;
                if (rec_pos >= len) begin
                    capturing  = 1'b0;
                    chunk_held = 1'b1;
                    play_pos   = 0;
                    n_chunks++;
                end
            end else begin
                r = play_pos % DEPTH;
                e.left   = blend(w.left, left_take[r]);
                e.right  = blend(w.right, right_take[r]);
                play_pos = r + 1;
                if (play_pos >= len) play_pos = 0;
                n_looped++;
            end
        end else begin
            capturing  = 1'b0;
            chunk_held = 1'b0;
            rec_pos    = 0;
            play_pos   = 0;
        end
        expected_q.push_back(e);
    endtask

    // Source side: present queued words, honouring each word's lead-in gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_wait = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(cur_word);
                n_words_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && src_wait >= pending_q[0].gap) begin
                    cur_word = pending_q.pop_front();
                    in_ch.stutter_on <= cur_word.stutter;
                    in_ch.in_left    <= cur_word.left;
                    in_ch.in_right   <= cur_word.right;
                    in_ch.valid      <= 1'b1;
                    src_wait = 0;
                end else begin
                    in_ch.valid <= 1'b0;
                    if (pending_q.size() != 0) src_wait++;
                end
            end
        end
    end

    // Sink side: random back-pressure and in-order comparison
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word L=%0d R=%0d",
                                              out_ch.out_left, out_ch.out_right));
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.out_left !== want.left)
                        report_mismatch($sformatf("word %0d out_left got %0d want %0d",
                                                  n_words_out, out_ch.out_left, want.left));
                    if (out_ch.out_right !== want.right)
                        report_mismatch($sformatf("word %0d out_right got %0d want %0d",
                                                  n_words_out, out_ch.out_right, want.right));
                end
                n_words_out++;
                sink_hold = $urandom_range(0, sink_stall_max);
            end else if (sink_hold != 0) begin
                sink_hold--;
            end
            out_ch.ready <= (sink_hold == 0);
        end
    end

    // Watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d idle cycles, %0d words still expected",
                 quiet_cycles, expected_q.size());
        $display("FAIL stereo_stutter_looper_core");
        $finish;
    end

    task automatic queue_word(input logic gate, input logic signed [15:0] l,
                              input logic signed [15:0] r);
        t_stim_word w;
        w.stutter = gate;
        w.left    = l;
        w.right   = r;
        w.gap     = 5'($urandom_range(0, source_gap_max));
        pending_q.push_back(w);
    endtask

    // Hold the source until everything queued has come back out
    task automatic settle();
        while (!(pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0))
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        n_phases++;
    endtask

    // APB write: setup cycle, then access cycle; written on the edge with pready high
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SSLC_ADDR_W'({idx, 2'b00});
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CHUNK_LEN: cfg_chunk     = v;
            REG_LOOP_GAIN: cfg_loop_gain = v;
            REG_DRY_GAIN:  cfg_dry_gain  = v;
            REG_WET_MIX:   cfg_wet_mix   = v;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // A longer loop over a held chunk could run into entries never written: clear first
    task automatic guard_growth();
        if (chunk_held && chunk_span() > take_extent)
            queue_word(1'b0, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            6: return 16'($urandom_range(32769, 65535));
            7: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_chunk();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom_range(32768, 65535));
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    initial begin
        int  p;
        int  k;
        bit  quiet;
        logic gate;

        // Known levels from time zero
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.stutter_on = 1'b0;
        in_ch.in_left    = '0;
        in_ch.in_right   = '0;
        out_ch.ready     = 1'b0;

        cfg_chunk      = SSLC_CHUNK_LEN_RST;
        cfg_loop_gain  = SSLC_LOOP_GAIN_RST;
        cfg_dry_gain   = SSLC_DRY_GAIN_RST;
        cfg_wet_mix    = SSLC_WET_MIX_RST;
        rec_pos        = 0;
        play_pos       = 0;
        capturing      = 1'b0;
        chunk_held     = 1'b0;
        take_extent    = 0;
        source_gap_max = 18;
        sink_stall_max = 18;
        src_wait       = 0;
        sink_hold      = 0;
        quiet_cycles   = 0;
        n_words_in     = 0;
        n_words_out    = 0;
        n_looped       = 0;
        n_chunks       = 0;
        n_reg_writes   = 0;
        n_phases       = 0;
        n_errors       = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: bypass, then start a long capture
        queue_word(1'b0, 16'sh7FFF, 16'sh8000);
        queue_word(1'b0, 16'sh8000, 16'sh7FFF);
        queue_word(1'b1, 16'sh0000, -16'sd1);
        queue_word(1'b1, 16'sh7FFF, 16'sh8000);
        queue_word(1'b1, -16'sd1,   16'sh0000);

        // Length shrunk under a capture already past it: ends on the next word
        settle();
        write_reg(REG_CHUNK_LEN, 16'd3);
        queue_word(1'b1, 16'sh1234, -16'sh1234);
        queue_word(1'b1, 16'sh7FFF, 16'sh8000);
        queue_word(1'b1, 16'sh8000, 16'sh7FFF);
        queue_word(1'b1, 16'sh0000, 16'sh0000);
        queue_word(1'b1, 16'sh4000, -16'sh4000);

        // Gains above unity clamp; loop plus full dry drives saturation both ways
        settle();
        write_reg(REG_LOOP_GAIN, 16'hFFFF);
        write_reg(REG_DRY_GAIN, 16'd32768);
        queue_word(1'b1, 16'sh7FFF, 16'sh8000);
        queue_word(1'b1, 16'sh8000, 16'sh7FFF);
        queue_word(1'b1, 16'sh0000, 16'sh0000);
        queue_word(1'b1, 16'sh8000, 16'sh7FFF);

        // Fully dry: loop has no effect
        settle();
        write_reg(REG_WET_MIX, 16'd0);
        write_reg(REG_LOOP_GAIN, 16'd0);
        write_reg(REG_DRY_GAIN, 16'd0);
        queue_word(1'b1, pick_sample(), pick_sample());
        queue_word(1'b1, pick_sample(), pick_sample());

        // Half-way blend exercises the rounding
        settle();
        write_reg(REG_WET_MIX, 16'd16384);
        write_reg(REG_LOOP_GAIN, 16'd16384);
        write_reg(REG_DRY_GAIN, 16'd12345);
        queue_word(1'b1, 16'($urandom), 16'($urandom));
        queue_word(1'b1, 16'($urandom), 16'($urandom));
        queue_word(1'b1, 16'($urandom), 16'($urandom));

        // Zero length acts as one: a one-sample loop
        settle();
        write_reg(REG_CHUNK_LEN, 16'd0);
        guard_growth();
        queue_word(1'b0, 16'sh0001, 16'sh0002);
        queue_word(1'b1, 16'sh7FFF, 16'sh8000);
        queue_word(1'b1, 16'($urandom), 16'($urandom));
        queue_word(1'b1, 16'($urandom), 16'($urandom));

        // Random phases: mostly gate-high runs, register changes between phases
        for (p = 0; p < 20; p++) begin
            settle();
            quiet          = ($urandom_range(0, 3) == 0);
            source_gap_max = quiet ? 0 : 18;
            sink_stall_max = quiet ? 0 : 18;
            if (p == 4)
                write_reg(REG_CHUNK_LEN, 16'hFFFF);
            else if (p == 5)
                write_reg(REG_CHUNK_LEN, 16'd5);
            else if ($urandom_range(0, 1) == 0)
                write_reg(REG_CHUNK_LEN, pick_chunk());
            if ($urandom_range(0, 2) == 0) write_reg(REG_LOOP_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0) write_reg(REG_DRY_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0) write_reg(REG_WET_MIX, pick_gain());
            guard_growth();
            for (k = 0; k < 25; k++) begin
                gate = ($urandom_range(0, 11) != 0);
                queue_word(gate, pick_sample(), pick_sample());
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", expected_q.size()));

        $display("covered %0d words in %0d phases: %0d chunks captured, %0d looped words",
                 n_words_in, n_phases, n_chunks, n_looped);
        $display("%0d register writes, %0d output words checked, %0d mismatches",
                 n_reg_writes, n_words_out, n_errors);
        if (n_errors == 0) begin
            $display("PASS stereo_stutter_looper_core");
        end else begin
            $display("FAIL stereo_stutter_looper_core");
        end
        $finish;
    end

endmodule
